[src/touch_frame_conditioner_unit_macros.svh]
// Assertion macros for the touch frame conditioner.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef TOUCH_FRAME_CONDITIONER_UNIT_MACROS_SVH
`define TOUCH_FRAME_CONDITIONER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TFC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TFC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[src/tfc_pkg.sv]
// Shared types and constants for the touch frame conditioner.
// No dependencies; imported by every module of the block.
`default_nettype none
package tfc_pkg;

    localparam int DEFAULT_MAX_SENSORS = 64;
    localparam int SAMPLE_W            = 16;
    localparam int SENSOR_COUNT_W      = 7;
    localparam int INDEX_W             = 6;
    localparam int CFG_DATA_W          = 16;
    localparam int CFG_INDEX_W         = 1;
    localparam int DIV_STEPS           = 16;
    localparam int DIV_STEP_W          = 4;

    localparam logic [SENSOR_COUNT_W-1:0] SENSOR_COUNT_RESET = 7'd60;

    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_THRESHOLD = 1'd1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_START,
        S_EMIT_DIV
    } tfc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tfc_div_stat_t;

endpackage
`default_nettype wire

[src/tfc_frame_mem.sv]
// Frame store: one write port, one read port with registered read data.
// Depends on tfc_pkg for the sample width.
`default_nettype none
module tfc_frame_mem
    import tfc_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MAX_SENSORS,
    parameter int ADDR_W = 6
)
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire logic [SAMPLE_W-1:0] wdata,
    input  wire logic                re,
    input  wire logic [ADDR_W-1:0]   raddr,
    output logic      [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/tfc_divider.sv]
// Restoring divider, one quotient bit per cycle: (dividend << 15) / divisor.
// Expects dividend <= divisor; depends on tfc_pkg.
`default_nettype none
module tfc_divider
    import tfc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SAMPLE_W-1:0] dividend,
    input  wire logic [SAMPLE_W-1:0] divisor,
    output logic      [SAMPLE_W-1:0] quotient,
    output tfc_div_stat_t            stat
);

    logic [SAMPLE_W:0]     rem_reg;
    logic [SAMPLE_W-1:0]   quot_reg;
    logic [SAMPLE_W-1:0]   dsr_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic              ge;
    logic [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] kept;

    always_comb
    begin
        diff = rem_reg - {1'b0, dsr_reg};
        ge   = rem_reg >= {1'b0, dsr_reg};
        kept = ge ? diff : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, dividend};
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= {kept[SAMPLE_W-1:0], 1'b0};
            quot_reg <= {quot_reg[SAMPLE_W-2:0], ge};
        end
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

[src/touch_frame_conditioner_unit.sv]
// Touch frame conditioner, top level: sequencer, config registers, output register.
// Depends on tfc_pkg, tfc_frame_mem, tfc_divider and the assertion macro header.
//
// Usage:
//   sample channel (sample_valid/sample_ready): one 16-bit reading per word, in
//   sensor order. Each word is written into the frame store as it is accepted.
//   When the last reading of a frame arrives, the block scans the store for the
//   frame maximum, then emits one result word per sensor on the result channel
//   (result_valid/result_ready). Each result takes one store read, one divider
//   load, the bit-serial divider's run for the level field and one output load.
//   No samples are taken during the scan and emit phases; the next frame's
//   first sample is taken as soon as the last result sits in the output register.
//   A stalled receiver holds the current result and freezes the sequencer.
//   Reset: sensor_count = 60, touch floor = 0, held maximum and load
//   position cleared, no result pending. Store contents are undefined until
//   written. cfg_we writes register cfg_index (0: sensor_count, 1: touch
//   floor) at once; write only while the block is idle.
`default_nettype none
`include "touch_frame_conditioner_unit_macros.svh"
module touch_frame_conditioner_unit
    import tfc_pkg::*;
#(
    parameter int MAX_SENSORS = DEFAULT_MAX_SENSORS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire logic [SAMPLE_W-1:0]    sample,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic      [INDEX_W-1:0]     sensor_index,
    output logic      [SAMPLE_W-1:0]    excess,
    output logic                        pressed,
    output logic      [SAMPLE_W-1:0]    level,
    output logic                        frame_touched,
    output logic                        last
);

    localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CW = $clog2(MAX_SENSORS + 1);

    tfc_state_t state_reg;
    tfc_state_t state_next;

    logic [SENSOR_COUNT_W-1:0] sensor_count_reg;
    logic [SAMPLE_W-1:0]       touch_floor_reg;
    logic [CW-1:0]             load_idx_reg;
    logic [CW-1:0]             frame_n_reg;
    logic [CW-1:0]             issue_reg;
    logic                      dv_reg;
    logic [SAMPLE_W-1:0]       frame_max_reg;
    logic [SAMPLE_W-1:0]       held_max_reg;
    logic [CW-1:0]             idx_reg;
    logic                      result_valid_reg;
    logic [SAMPLE_W-1:0]       excess_pend_reg;

    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       pos;
    logic                pos_last;
    logic                scan_done;
    logic                idx_last;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [SAMPLE_W-1:0] rd_data;
    logic                div_start;
    logic                out_load;
    logic [SAMPLE_W-1:0] quotient;
    tfc_div_stat_t       div_stat;
    logic [SAMPLE_W-1:0] excess_calc;

    always_comb
    begin
        if (sensor_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (sensor_count_reg > SENSOR_COUNT_W'(MAX_SENSORS))
        begin
            n_eff = CW'(MAX_SENSORS);
        end
        else
        begin
            n_eff = CW'(sensor_count_reg);
        end
        pos         = (load_idx_reg >= CW'(MAX_SENSORS)) ? CW'(MAX_SENSORS - 1) : load_idx_reg;
        pos_last    = (pos + 1'b1) >= n_eff;
        scan_done   = (issue_reg == frame_n_reg) && !dv_reg;
        idx_last    = idx_reg == (frame_n_reg - 1'b1);
        excess_calc = (rd_data > touch_floor_reg) ? (rd_data - touch_floor_reg) : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (sample_valid && pos_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_START;
            end
            S_EMIT_START:
            begin
                state_next = S_EMIT_DIV;
            end
            S_EMIT_DIV:
            begin
                if (out_load)
                begin
                    state_next = idx_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        sample_ready = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg[AW-1:0];
        div_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                sample_ready = 1'b1;
                mem_we       = sample_valid;
            end
            S_SCAN:
            begin
                mem_re    = issue_reg < frame_n_reg;
                mem_raddr = issue_reg[AW-1:0];
            end
            S_EMIT_RD:
            begin
                mem_re = 1'b1;
            end
            S_EMIT_START:
            begin
                div_start = 1'b1;
            end
            S_EMIT_DIV:
            begin
                out_load = div_stat.done && (!result_valid_reg || result_ready);
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_LOAD;
            sensor_count_reg    <= SENSOR_COUNT_RESET;
            touch_floor_reg     <= '0;
            load_idx_reg        <= '0;
            frame_n_reg         <= CW'(1);
            issue_reg           <= '0;
            dv_reg              <= 1'b0;
            frame_max_reg       <= '0;
            held_max_reg        <= '0;
            idx_reg             <= '0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SENSOR_COUNT:    sensor_count_reg    <= cfg_data[SENSOR_COUNT_W-1:0];
                    REG_NOISE_THRESHOLD: touch_floor_reg     <= cfg_data[SAMPLE_W-1:0];
                    default:             sensor_count_reg    <= sensor_count_reg;
                endcase
            end
            if (mem_we)
            begin
                load_idx_reg <= pos_last ? '0 : (pos + 1'b1);
                if (pos_last)
                begin
                    frame_n_reg   <= n_eff;
                    issue_reg     <= '0;
                    dv_reg        <= 1'b0;
                    frame_max_reg <= '0;
                end
            end
            if (state_reg == S_SCAN)
            begin
                issue_reg <= issue_reg + CW'(mem_re);
                dv_reg    <= mem_re;
                if (dv_reg && (rd_data > frame_max_reg))
                begin
                    frame_max_reg <= rd_data;
                end
                if (scan_done)
                begin
                    idx_reg <= '0;
                    if (frame_max_reg > held_max_reg)
                    begin
                        held_max_reg <= frame_max_reg;
                    end
                end
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
                idx_reg          <= idx_reg + 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            excess_pend_reg <= excess_calc;
        end
        if (out_load)
        begin
            sensor_index  <= INDEX_W'(idx_reg);
            excess        <= excess_pend_reg;
            pressed       <= |excess_pend_reg;
            level         <= ((|excess_pend_reg) && (|held_max_reg)) ? quotient : '0;
            frame_touched <= |frame_max_reg;
            last          <= idx_last;
        end
    end

    assign result_valid = result_valid_reg;

    tfc_frame_mem #(
        .DEPTH  (MAX_SENSORS),
        .ADDR_W (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pos[AW-1:0]),
        .wdata (sample),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    tfc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data),
        .divisor  (held_max_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    `TFC_ASSERT(a_held_max_grows, clk, rst_n, held_max_reg >= $past(held_max_reg), "held maximum decreased")
    `TFC_NEVER(a_start_while_busy, clk, rst_n, div_start && div_stat.busy, "divider restarted while busy")
    `TFC_ASSERT(a_level_range, clk, rst_n, result_valid && pressed |-> level <= 16'h8000, "level above one")
    `TFC_ASSERT(a_level_unpressed, clk, rst_n, result_valid && !pressed |-> level == '0, "level set on an unpressed sensor")
    `TFC_ASSERT(a_last_index, clk, rst_n, out_load && idx_last |=> state_reg == S_LOAD && load_idx_reg == '0, "frame end without return to load")

endmodule
`default_nettype wire
